// ===== rtl/core/d2q_pkg.sv =====
`default_nettype none
package d2q_pkg;

  localparam int DW = 32;          // Q2.30 word
  localparam int FB = DW - 2;      // fraction bits
  localparam int RW = DW + 1;      // radicand, numerator magnitude, divisor
  localparam int NL = 3;           // divider lanes

  typedef enum logic [1:0] {
    POS_Q0 = 2'd0,
    POS_Q1 = 2'd1,
    POS_Q2 = 2'd2,
    POS_Q3 = 2'd3
  } lead_pos_t;

  typedef struct packed {
    lead_pos_t                pos;
    logic [NL-1:0]            neg;
    logic [NL-1:0][RW-1:0]    mag;
  } side_t;

  function automatic logic [DW-1:0] sat(input logic neg, input logic ovf,
                                        input logic [DW-1:0] q);
    logic [DW-1:0] r;
    if (!neg) begin
      r = (ovf || q[DW-1]) ? {1'b0, {(DW-1){1'b1}}} : q;
    end else begin
      r = (ovf || (q[DW-1] && (q[DW-2:0] != '0))) ? {1'b1, {(DW-1){1'b0}}}
                                                  : (~q + 1'b1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/d2q_mat_if.sv =====
`default_nettype none
interface d2q_mat_if;
  import d2q_pkg::*;
  logic valid;
  logic ready;
  logic signed [DW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/core/d2q_quat_if.sv =====
`default_nettype none
interface d2q_quat_if;
  import d2q_pkg::*;
  logic valid;
  logic ready;
  logic signed [DW-1:0] q_scalar, q_x, q_y, q_z;
  modport source (output valid, q_scalar, q_x, q_y, q_z, input ready);
  modport sink (input valid, q_scalar, q_x, q_y, q_z, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/d2q_sqrt.sv =====
`default_nettype none
module d2q_sqrt (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_vld,
  input  wire logic [d2q_pkg::RW-1:0] in_s,
  input  wire d2q_pkg::side_t     in_side,
  output logic                    out_vld,
  output logic [d2q_pkg::DW-1:0]  out_root,
  output d2q_pkg::side_t          out_side
);
  import d2q_pkg::*;

  localparam int NS = DW;   // one root bit per stage

  typedef struct packed {
    logic [RW-1:0] s;
    logic [RW-1:0] rem;
    logic [DW-1:0] res;
    side_t         side;
  } sq_t;

  logic [NS:0] vld;
  sq_t         st [NS:0];

  assign vld[0]      = in_vld;
  assign st[0].s     = in_s;
  assign st[0].rem   = '0;
  assign st[0].res   = '0;
  assign st[0].side  = in_side;

  for (genvar k = 0; k < NS; k++) begin : g_st
    logic [2*DW-1:0] v;
    logic [RW+1:0]   cur;
    logic [RW+1:0]   trial;
    assign v     = {1'b0, st[k].s, {FB{1'b0}}};
    assign cur   = {st[k].rem, v[2*DW-1-2*k -: 2]};
    assign trial = {1'b0, st[k].res, 2'b01};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1].s    <= st[k].s;
        st[k+1].side <= st[k].side;
        if (cur >= trial) begin
          st[k+1].rem <= RW'(cur - trial);
          st[k+1].res <= {st[k].res[DW-2:0], 1'b1};
        end else begin
          st[k+1].rem <= RW'(cur);
          st[k+1].res <= {st[k].res[DW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vld[NS];
  assign out_root = st[NS].res;
  assign out_side = st[NS].side;
endmodule
`default_nettype wire

// ===== rtl/core/d2q_div.sv =====
`default_nettype none
module d2q_div (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire logic                   in_vld,
  input  wire logic [d2q_pkg::DW-1:0] in_root,
  input  wire d2q_pkg::side_t         in_side,
  output logic                        out_vld,
  output logic                        out_zr,
  output d2q_pkg::lead_pos_t          out_pos,
  output logic [d2q_pkg::DW-1:0]      out_lead,
  output logic [d2q_pkg::NL-1:0]      out_neg,
  output logic [d2q_pkg::NL-1:0]      out_ovf,
  output logic [d2q_pkg::NL-1:0][d2q_pkg::DW-1:0] out_q
);
  import d2q_pkg::*;

  localparam int ND = DW;   // one quotient bit per stage

  typedef struct packed {
    logic                  zr;
    lead_pos_t             pos;
    logic [DW-1:0]         lead;
    logic [NL-1:0]         neg;
    logic [NL-1:0]         ovf;
    logic [NL-1:0][1:0]    lowb;
    logic [NL-1:0][RW-1:0] rem;
    logic [NL-1:0][DW-1:0] q;
    logic [RW-1:0]         d;
  } dv_t;

  logic [ND:0] vld;
  dv_t         st [ND:0];
  logic [RW-1:0] d_in;

  assign d_in = {in_root, 1'b0};

  // quotient bits above DW only flag overflow
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0].zr   <= (in_root == '0);
      st[0].pos  <= in_side.pos;
      st[0].lead <= {1'b0, in_root[DW-1:1]};
      st[0].neg  <= in_side.neg;
      st[0].d    <= d_in;
      st[0].q    <= '0;
      for (int l = 0; l < NL; l++) begin
        st[0].rem[l]  <= {2'b00, in_side.mag[l][RW-1:2]};
        st[0].ovf[l]  <= ({2'b00, in_side.mag[l][RW-1:2]} >= d_in);
        st[0].lowb[l] <= in_side.mag[l][1:0];
      end
    end
  end

  for (genvar j = 0; j < ND; j++) begin : g_st
    logic [NL-1:0][RW:0] cur;
    for (genvar l = 0; l < NL; l++) begin : g_ln
      logic b;
      assign b = (j == 0) ? st[j].lowb[l][1] : ((j == 1) ? st[j].lowb[l][0] : 1'b0);
      assign cur[l] = {st[j].rem[l], b};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else if (en) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[j+1].zr   <= st[j].zr;
        st[j+1].pos  <= st[j].pos;
        st[j+1].lead <= st[j].lead;
        st[j+1].neg  <= st[j].neg;
        st[j+1].ovf  <= st[j].ovf;
        st[j+1].lowb <= st[j].lowb;
        st[j+1].d    <= st[j].d;
        for (int l = 0; l < NL; l++) begin
          if (cur[l] >= {1'b0, st[j].d}) begin
            st[j+1].rem[l] <= RW'(cur[l] - {1'b0, st[j].d});
            st[j+1].q[l]   <= {st[j].q[l][DW-2:0], 1'b1};
          end else begin
            st[j+1].rem[l] <= RW'(cur[l]);
            st[j+1].q[l]   <= {st[j].q[l][DW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_vld  = vld[ND];
  assign out_zr   = st[ND].zr;
  assign out_pos  = st[ND].pos;
  assign out_lead = st[ND].lead;
  assign out_neg  = st[ND].neg;
  assign out_ovf  = st[ND].ovf;
  assign out_q    = st[ND].q;
endmodule
`default_nettype wire

// ===== rtl/core/dcm_to_quaternion.sv =====
// Direction cosine matrix to quaternion converter (Shepperd's method).
// mat (sink): one word per matrix, nine signed Q2.30 elements m00..m22.
// quat (source): one word per matrix, scalar-first quaternion in Q2.30,
// saturated to the signed 32-bit range.
// Branch: trace when the trace is positive, else the largest diagonal.
// Pipeline: 1 setup stage, 32 square-root stages (one root bit each),
// 1 divider setup stage, 32 divider stages (one quotient bit each, three
// lanes sharing the divisor 2r), 1 output register.
// Depth: 67 register stages.
// Throughput: one word per cycle unless quat.ready stalls the output; the
// per-bit sqrt and divide stages set the depth.
// Reset: clears all valid bits; the pipeline is empty after reset.
// Stall: when the output word is held and quat.ready is low, the whole
// pipeline freezes and mat.ready drops; nothing is lost or repeated.
`default_nettype none
module dcm_to_quaternion (
  input wire logic   clk,
  input wire logic   rst,
  d2q_mat_if.sink    mat,
  d2q_quat_if.source quat
);
  import d2q_pkg::*;

  localparam int XW = DW + 3;

  logic en;
  logic ov;
  assign en        = !ov || quat.ready;
  assign mat.ready = en;
  assign quat.valid = ov;

  function automatic logic signed [XW-1:0] ex(input logic signed [DW-1:0] a);
    return XW'(a);
  endfunction

  function automatic logic signed [RW-1:0] nx(input logic signed [DW-1:0] a);
    return RW'(a);
  endfunction

  logic signed [XW-1:0] tr, rad;
  logic signed [XW-1:0] one;
  logic signed [RW-1:0] n [NL];
  lead_pos_t            pos;
  side_t                side_c;

  assign one = XW'(1) <<< FB;
  assign tr  = ex(mat.m00) + ex(mat.m11) + ex(mat.m22);

  always_comb begin
    if (!tr[XW-1] && (tr != '0)) begin
      pos  = POS_Q0;
      rad  = tr + one;
      n[0] = nx(mat.m12) - nx(mat.m21);
      n[1] = nx(mat.m20) - nx(mat.m02);
      n[2] = nx(mat.m01) - nx(mat.m10);
    end else if ((mat.m11 > mat.m00) && (mat.m11 > mat.m22)) begin
      pos  = POS_Q2;
      rad  = ex(mat.m11) - ex(mat.m00) + one - ex(mat.m22);
      n[0] = nx(mat.m20) - nx(mat.m02);
      n[1] = nx(mat.m01) + nx(mat.m10);
      n[2] = nx(mat.m12) + nx(mat.m21);
    end else if (mat.m22 > mat.m00) begin
      pos  = POS_Q3;
      rad  = ex(mat.m22) - ex(mat.m00) + one - ex(mat.m11);
      n[0] = nx(mat.m01) - nx(mat.m10);
      n[1] = nx(mat.m20) + nx(mat.m02);
      n[2] = nx(mat.m12) + nx(mat.m21);
    end else begin
      pos  = POS_Q1;
      rad  = ex(mat.m00) - ex(mat.m11) + one - ex(mat.m22);
      n[0] = nx(mat.m12) - nx(mat.m21);
      n[1] = nx(mat.m01) + nx(mat.m10);
      n[2] = nx(mat.m20) + nx(mat.m02);
    end
    side_c.pos = pos;
    for (int l = 0; l < NL; l++) begin
      side_c.neg[l] = n[l][RW-1];
      side_c.mag[l] = n[l][RW-1] ? RW'(-n[l]) : RW'(n[l]);
    end
  end

  logic          p_vld;
  logic [RW-1:0] p_s;
  side_t         p_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else if (en) begin
      p_vld <= mat.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_s    <= rad[XW-1] ? '0 : rad[RW-1:0];
      p_side <= side_c;
    end
  end

  logic          s_vld;
  logic [DW-1:0] s_root;
  side_t         s_side;

  d2q_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (p_vld),
    .in_s     (p_s),
    .in_side  (p_side),
    .out_vld  (s_vld),
    .out_root (s_root),
    .out_side (s_side)
  );

  logic                  d_vld, d_zr;
  lead_pos_t             d_pos;
  logic [DW-1:0]         d_lead;
  logic [NL-1:0]         d_neg, d_ovf;
  logic [NL-1:0][DW-1:0] d_q;

  d2q_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (s_vld),
    .in_root  (s_root),
    .in_side  (s_side),
    .out_vld  (d_vld),
    .out_zr   (d_zr),
    .out_pos  (d_pos),
    .out_lead (d_lead),
    .out_neg  (d_neg),
    .out_ovf  (d_ovf),
    .out_q    (d_q)
  );

  logic [DW-1:0] v [NL];
  logic [DW-1:0] lead;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      v[l] = d_zr ? '0 : sat(d_neg[l], d_ovf[l], d_q[l]);
    end
    lead = d_zr ? '0 : d_lead;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (en) begin
      ov <= d_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      case (d_pos)
        POS_Q0: begin
          quat.q_scalar <= lead; quat.q_x <= v[0]; quat.q_y <= v[1]; quat.q_z <= v[2];
        end
        POS_Q1: begin
          quat.q_scalar <= v[0]; quat.q_x <= lead; quat.q_y <= v[1]; quat.q_z <= v[2];
        end
        POS_Q2: begin
          quat.q_scalar <= v[0]; quat.q_x <= v[1]; quat.q_y <= lead; quat.q_z <= v[2];
        end
        default: begin
          quat.q_scalar <= v[0]; quat.q_x <= v[1]; quat.q_y <= v[2]; quat.q_z <= lead;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== sim/tb_dcm_to_quaternion.sv =====
`default_nettype none
module tb_dcm_to_quaternion;
  import d2q_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } dcm_t;

  typedef struct packed {
    logic signed [DW-1:0] q0, q1, q2, q3;
  } quat_t;

  localparam longint ONE = 64'sd1 << FB;
  localparam logic signed [DW-1:0] ONE_W = DW'(ONE);
  localparam int unsigned ONE_U = 32'd1 << FB;
  localparam longint PMAX = 64'sd2147483647;
  localparam int WATCHDOG = 5000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  d2q_mat_if mat ();
  d2q_quat_if quat ();

  dcm_to_quaternion dut (.clk(clk), .rst(rst), .mat(mat), .quat(quat));

  dcm_t pending_q[$];
  quat_t quat_exp_q[$];
  int errors = 0;
  bit stim_done = 1'b0;
  int idle_cycles = 0;

  function automatic logic [DW-1:0] clamp_word(bit neg, longint unsigned mag);
    if (!neg) return (mag > PMAX) ? PMAX[DW-1:0] : mag[DW-1:0];
    if (mag > PMAX + 1) mag = PMAX + 1;
    return DW'(64'd0 - mag);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned root_q(longint s);
    if (s <= 0) return 0;
    return int_sqrt(longint'(s) << FB);
  endfunction

  function automatic logic [DW-1:0] div_root(longint num, longint unsigned r);
    longint unsigned mag;
    if (r == 0) return '0;
    mag = (num < 0) ? -num : num;
    return clamp_word(num < 0, (mag << FB) / (r << 1));
  endfunction

  function automatic quat_t dcm_to_quat(dcm_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr;
    longint unsigned r;
    logic [DW-1:0] lead;
    quat_t q;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      r = root_q(tr + ONE);
      lead = clamp_word(0, r >> 1);
      q = '{lead, div_root(a12 - a21, r), div_root(a20 - a02, r), div_root(a01 - a10, r)};
    end else if (a11 > a00 && a11 > a22) begin
      r = root_q(a11 - a00 + ONE - a22);
      lead = clamp_word(0, r >> 1);
      q = '{div_root(a20 - a02, r), div_root(a01 + a10, r), lead, div_root(a12 + a21, r)};
    end else if (a22 > a00) begin
      r = root_q(a22 - a00 + ONE - a11);
      lead = clamp_word(0, r >> 1);
      q = '{div_root(a01 - a10, r), div_root(a20 + a02, r), div_root(a12 + a21, r), lead};
    end else begin
      r = root_q(a00 - a11 + ONE - a22);
      lead = clamp_word(0, r >> 1);
      q = '{div_root(a12 - a21, r), lead, div_root(a01 + a10, r), div_root(a20 + a02, r)};
    end
    return q;
  endfunction

  // driver
  int src_wait = 0;
  always @(posedge clk) begin
    if (rst) begin
      mat.valid <= 1'b0;
    end else begin
      if (mat.valid && mat.ready) begin
        quat_exp_q.push_back(dcm_to_quat({mat.m00, mat.m01, mat.m02, mat.m10, mat.m11,
                                          mat.m12, mat.m20, mat.m21, mat.m22}));
        void'(pending_q.pop_front());
        src_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if ($urandom_range(0, 1)) src_wait = 0;
      end
      if (!(mat.valid && !mat.ready)) begin
        if (src_wait > 0) begin
          src_wait--;
          mat.valid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          mat.valid <= 1'b1;
          {mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12, mat.m20, mat.m21,
           mat.m22} <= pending_q[0];
        end else begin
          mat.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int snk_wait = 0;
  always @(posedge clk) begin
    quat_t got, want;
    if (rst) begin
      quat.ready <= 1'b0;
    end else begin
      if (quat.valid && quat.ready) begin
        got = '{quat.q_scalar, quat.q_x, quat.q_y, quat.q_z};
        if (quat_exp_q.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          errors++;
        end else begin
          want = quat_exp_q.pop_front();
          if (got.q0 !== want.q0)
            $display("%0t: q_scalar exp %h got %h", $time, want.q0, got.q0);
          if (got.q1 !== want.q1)
            $display("%0t: q_x exp %h got %h", $time, want.q1, got.q1);
          if (got.q2 !== want.q2)
            $display("%0t: q_y exp %h got %h", $time, want.q2, got.q2);
          if (got.q3 !== want.q3)
            $display("%0t: q_z exp %h got %h", $time, want.q3, got.q3);
          if (got !== want) errors++;
        end
        snk_wait = $urandom_range(0, 1) ? 0 : $urandom_range(0, 18);
      end
      if (snk_wait > 0) begin
        snk_wait--;
        quat.ready <= 1'b0;
      end else begin
        quat.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((mat.valid && mat.ready) || (quat.valid && quat.ready)) idle_cycles <= 0;
    else if (!rst) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic signed [DW-1:0] rnd_elem();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return {1'b1, {(DW-1){1'b0}}};
      2: return {1'b0, {(DW-1){1'b1}}};
      default: return DW'(longint'($urandom_range(0, 2 * ONE_U)) - ONE);
    endcase
  endfunction

  // near-rotation: diagonal picked to steer the branch, off-diagonals from rnd_elem
  function automatic dcm_t rnd_rotation_like();
    dcm_t m;
    int br;
    m = '{rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(),
          rnd_elem(), rnd_elem(), rnd_elem()};
    br = $urandom_range(0, 3);
    m.m00 = DW'(longint'($urandom_range(0, ONE_U)) - (br == 1 ? 64'sd0 : ONE));
    m.m11 = DW'(longint'($urandom_range(0, ONE_U)) - (br == 2 ? 64'sd0 : ONE));
    m.m22 = DW'(longint'($urandom_range(0, ONE_U)) - (br == 3 ? 64'sd0 : ONE));
    if (br == 0) begin
      m.m00 = $urandom_range(0, ONE_U);
      m.m11 = $urandom_range(0, ONE_U);
      m.m22 = $urandom_range(0, ONE_U);
    end
    return m;
  endfunction

  initial begin
    dcm_t m;
    mat.valid = 1'b0;
    quat.ready = 1'b0;
    {mat.m00, mat.m01, mat.m02, mat.m10, mat.m11, mat.m12, mat.m20, mat.m21, mat.m22} = '0;
    // identity, trace branch
    pending_q.push_back('{ONE_W, 0, 0, 0, ONE_W, 0, 0, 0, ONE_W});
    // 180 deg about each axis: m00, m11, m22 branches
    pending_q.push_back('{ONE_W, 0, 0, 0, -ONE_W, 0, 0, 0, -ONE_W});
    pending_q.push_back('{-ONE_W, 0, 0, 0, ONE_W, 0, 0, 0, -ONE_W});
    pending_q.push_back('{-ONE_W, 0, 0, 0, -ONE_W, 0, 0, 0, ONE_W});
    // all zero: diagonal tie, m00 branch
    pending_q.push_back('0);
    // ties on diagonal
    pending_q.push_back('{-ONE_W, 5, 6, 7, -ONE_W, 8, 9, 10, -ONE_W / 2});
    pending_q.push_back('{-ONE_W / 2, 5, 6, 7, -ONE_W / 2, 8, 9, 10, -ONE_W});
    // extreme diagonal (trace branch) and equal diagonal of -1 (m00 branch)
    m = '{32'sh80000000, 1, 2, 3, 32'sh7fffffff, 4, 5, 6, 32'sh7fffffff};
    pending_q.push_back(m);
    pending_q.push_back('{-ONE_W, 3, 3, 3, -ONE_W, 3, 3, 3, -ONE_W});
    // extremes: saturation of dependent components
    m = '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh80000000,
          32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000};
    pending_q.push_back(m);
    m = '{1, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 0, 32'sh80000000,
          32'sh80000000, 32'sh7fffffff, 0};
    pending_q.push_back(m);
    pending_q.push_back('{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                          32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                          32'sh7fffffff});
    pending_q.push_back('{9{32'sh80000000}});
    pending_q.push_back('{9{32'hffffffff}});
    pending_q.push_back('{1, 0, 0, 0, 0, 0, 0, 0, 0});
    repeat (650) begin
      if ($urandom_range(0, 3) == 0)
        m = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom};
      else
        m = rnd_rotation_like();
      pending_q.push_back(m);
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (pending_q.size() == 0);
    wait (quat_exp_q.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire
